FILE: rtl/core/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg
// shared types, constants and step functions for the cable and rod contact
// generator
// ----------------------------------------------------------------------------
package dcc_pkg;

  // index pass-through width, masked onto the 16-bit result fields
  localparam int IndexBits = 16;
  localparam logic [15:0] IndexMask =
    (IndexBits >= 16) ? 16'hFFFF : 16'((32'd1 << IndexBits) - 32'd1);

  // one root bit per square root stage, one quotient bit per divide stage
  localparam int SqrtSteps = 33;
  localparam int DivSteps  = 15;

  // queue between front and back
  localparam int MidDepth = 4;
  localparam int MidPtrW  = 2;
  localparam int MidCntW  = 3;

  // result queue
  localparam int OutDepth = 2;
  localparam int OutPtrW  = 1;
  localparam int OutCntW  = 2;

  localparam logic [15:0] NormMax = 16'h7FFF;
  localparam logic [31:0] PenMax  = 32'hFFFF_FFFF;

  typedef enum logic {
    KIND_CABLE = 1'b0,
    KIND_ROD   = 1'b1
  } kind_t;

  // constraint as it travels through the front
  typedef struct packed {
    kind_t            kind;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic [31:0]      limit;
    logic [15:0]      bounce;
    logic [15:0]      idx_a;
    logic [15:0]      idx_b;
  } front_t;

  // square root working state
  typedef struct packed {
    front_t      f;
    logic [33:0] rem;
    logic [32:0] root;
    logic [65:0] rad;
  } root_t;

  // classified contact handed from front to back
  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic [32:0]      sep;
    logic             flip;
    logic [31:0]      pen;
    logic [15:0]      rest;
    logic [15:0]      idx_a;
    logic [15:0]      idx_b;
  } mid_t;

  // divide working state, three lanes
  typedef struct packed {
    mid_t             m;
    logic [2:0][32:0] rem;
    logic [2:0][14:0] quo;
    logic [2:0]       sat;
  } div_t;

  typedef struct packed {
    logic [2:0][15:0] normal;
    logic [31:0]      pen;
    logic [15:0]      rest;
    logic [15:0]      idx_a;
    logic [15:0]      idx_b;
  } result_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [14:0] quo;
  } lane_t;

  // one restoring square root step: two radicand bits in, one root bit out
  function automatic root_t root_step(root_t s);
    root_t       o;
    logic [35:0] r;
    logic [35:0] t;
    o = s;
    r = {s.rem, s.rad[65:64]};
    t = {1'b0, s.root, 2'b01};
    if (r >= t) begin
      o.rem  = 34'(r - t);
      o.root = {s.root[31:0], 1'b1};
    end else begin
      o.rem  = r[33:0];
      o.root = {s.root[31:0], 1'b0};
    end
    o.rad = {s.rad[63:0], 2'b00};
    return o;
  endfunction

  // one restoring divide step with a zero numerator bit shifted in
  function automatic lane_t div_step(lane_t s, logic [32:0] sep);
    lane_t       o;
    logic [33:0] r2;
    r2 = {s.rem, 1'b0};
    if (r2 >= {1'b0, sep}) begin
      o.rem = 33'(r2 - {1'b0, sep});
      o.quo = {s.quo[13:0], 1'b1};
    end else begin
      o.rem = r2[32:0];
      o.quo = {s.quo[13:0], 1'b0};
    end
    return o;
  endfunction

endpackage

FILE: rtl/core/distance_constraint_contact.sv
// ----------------------------------------------------------------------------
// distance_constraint_contact
// contact generation for particle cables and rods in fixed point
// ----------------------------------------------------------------------------
// One constraint is taken per cycle while in_full is low. An item passes the
// difference, square and seed registers, 33 square root stages (one root bit
// each) and one classification stage, then sits in a four-entry queue; the
// back takes one contact per cycle, unless stalled, through 15 divide stages
// (one normal bit per stage, three lanes) into a two-entry result queue. A
// constraint that makes no contact gives no result. Stalls come only from full
// queues.
module distance_constraint_contact
  import dcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_kind,
  input  logic [31:0] in_first_x,
  input  logic [31:0] in_first_y,
  input  logic [31:0] in_first_z,
  input  logic [31:0] in_second_x,
  input  logic [31:0] in_second_y,
  input  logic [31:0] in_second_z,
  input  logic [31:0] in_limit_length,
  input  logic [15:0] in_bounce_factor,
  input  logic [15:0] in_first_index,
  input  logic [15:0] in_second_index,
  output logic        out_empty,
  input  logic        out_pop,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic [31:0] out_penetration,
  output logic [15:0] out_contact_restitution,
  output logic [15:0] out_contact_first,
  output logic [15:0] out_contact_second
);

  logic    mq_push, mq_full, mq_pop, mq_empty;
  mid_t    mq_wdata, mq_rdata;
  logic    rq_push, rq_full;
  result_t rq_wdata, rq_rdata;

  // front: geometry and classification
  dcc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_kind          (in_kind),
    .in_first_x       (in_first_x),
    .in_first_y       (in_first_y),
    .in_first_z       (in_first_z),
    .in_second_x      (in_second_x),
    .in_second_y      (in_second_y),
    .in_second_z      (in_second_z),
    .in_limit_length  (in_limit_length),
    .in_bounce_factor (in_bounce_factor),
    .in_first_index   (in_first_index),
    .in_second_index  (in_second_index),
    .q_push           (mq_push),
    .q_data           (mq_wdata),
    .q_full           (mq_full)
  );

  // decoupling queue
  dcc_mid_queue u_mid_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mq_push),
    .push_data (mq_wdata),
    .full      (mq_full),
    .pop       (mq_pop),
    .pop_data  (mq_rdata),
    .empty     (mq_empty)
  );

  // back: normal division
  dcc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (mq_empty),
    .q_data  (mq_rdata),
    .q_pop   (mq_pop),
    .r_push  (rq_push),
    .r_data  (rq_wdata),
    .r_full  (rq_full)
  );

  // result queue
  dcc_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rq_push),
    .push_data (rq_wdata),
    .full      (rq_full),
    .pop       (out_pop),
    .pop_data  (rq_rdata),
    .empty     (out_empty)
  );

  assign out_normal_x            = rq_rdata.normal[0];
  assign out_normal_y            = rq_rdata.normal[1];
  assign out_normal_z            = rq_rdata.normal[2];
  assign out_penetration         = rq_rdata.pen;
  assign out_contact_restitution = rq_rdata.rest;
  assign out_contact_first       = rq_rdata.idx_a;
  assign out_contact_second      = rq_rdata.idx_b;

`ifndef SYNTHESIS
  // a normal component never reaches minus full scale
  a_no_min_normal: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_normal_x != 16'sh8000 && out_normal_y != 16'sh8000 &&
                    out_normal_z != 16'sh8000))
    else $error("normal component at minus full scale");

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result present after reset");

  // a waiting result holds until it is popped
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_penetration) &&
                                  $stable(out_contact_first)))
    else $error("waiting result changed without a transfer");
`endif

endmodule

FILE: rtl/core/dcc_mid_queue.sv
// ----------------------------------------------------------------------------
// dcc_mid_queue
// small register queue carrying classified contacts from front to back
// ----------------------------------------------------------------------------
module dcc_mid_queue
  import dcc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  mid_t push_data,
  output logic full,
  input  logic pop,
  output mid_t pop_data,
  output logic empty
);

  mid_t               mem_r [MidDepth];
  logic [MidPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [MidPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [MidCntW-1:0] cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  assign full     = (cnt_r == MidCntW'(MidDepth));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_wr    = push & ~full;
  assign do_rd    = pop & ~empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_wr ? MidPtrW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? MidPtrW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = MidCntW'(cnt_r + 1'b1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = MidCntW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/dcc_out_queue.sv
// ----------------------------------------------------------------------------
// dcc_out_queue
// result queue that parts the back pipeline from the consumer
// ----------------------------------------------------------------------------
module dcc_out_queue
  import dcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  input  logic    pop,
  output result_t pop_data,
  output logic    empty
);

  result_t            mem_r [OutDepth];
  logic [OutPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OutPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OutCntW-1:0] cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  assign full     = (cnt_r == OutCntW'(OutDepth));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_wr    = push & ~full;
  assign do_rd    = pop & ~empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_wr ? OutPtrW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? OutPtrW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = OutCntW'(cnt_r + 1'b1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = OutCntW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/dcc_front.sv
// ----------------------------------------------------------------------------
// dcc_front
// difference, squares, pipelined square root and contact classification
// ----------------------------------------------------------------------------
module dcc_front
  import dcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_kind,
  input  logic [31:0] in_first_x,
  input  logic [31:0] in_first_y,
  input  logic [31:0] in_first_z,
  input  logic [31:0] in_second_x,
  input  logic [31:0] in_second_y,
  input  logic [31:0] in_second_z,
  input  logic [31:0] in_limit_length,
  input  logic [15:0] in_bounce_factor,
  input  logic [15:0] in_first_index,
  input  logic [15:0] in_second_index,
  output logic        q_push,
  output mid_t        q_data,
  input  logic        q_full
);

  logic             adv;
  logic [2:0][31:0] pa, pb;
  front_t           p0_nxt;
  front_t           p0_r;
  logic             p0_vld_r;
  front_t           p1_r;
  logic [2:0][63:0] sq_r;
  logic             p1_vld_r;
  root_t            sr_r   [SqrtSteps+1];
  logic [SqrtSteps:0] sr_vld_r;
  root_t            sr_init;
  mid_t             cl_nxt;
  logic             emit_nxt;
  mid_t             cl_r;
  logic             cl_vld_r;
  logic             cl_emit_r;

  // the whole front moves unless a contact waits on a full queue
  assign adv     = ~(cl_vld_r & cl_emit_r & q_full);
  assign in_full = ~adv;
  assign q_push  = cl_vld_r & cl_emit_r & ~q_full;
  assign q_data  = cl_r;

  assign pa = {in_first_z, in_first_y, in_first_x};
  assign pb = {in_second_z, in_second_y, in_second_x};

  // signed difference and magnitude per axis
  always_comb begin
    logic [32:0] d;
    p0_nxt        = '0;
    p0_nxt.kind   = kind_t'(in_kind);
    p0_nxt.limit  = in_limit_length;
    p0_nxt.bounce = in_bounce_factor;
    p0_nxt.idx_a  = in_first_index & IndexMask;
    p0_nxt.idx_b  = in_second_index & IndexMask;
    for (int i = 0; i < 3; i++) begin
      d              = {pb[i][31], pb[i]} - {pa[i][31], pa[i]};
      p0_nxt.neg[i]  = d[32];
      p0_nxt.mag[i]  = d[32] ? 32'(-d) : d[31:0];
    end
  end

  // sum of squares seeds the root pipeline
  always_comb begin
    sr_init      = '0;
    sr_init.f    = p1_r;
    sr_init.rad  = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
  end

  // distance against limit
  always_comb begin
    logic [32:0] sep;
    logic [32:0] lim;
    logic [32:0] err;
    front_t      f;
    f           = sr_r[SqrtSteps].f;
    sep         = sr_r[SqrtSteps].root;
    lim         = {1'b0, f.limit};
    err         = (sep >= lim) ? 33'(sep - lim) : 33'(lim - sep);
    cl_nxt      = '0;
    cl_nxt.neg  = f.neg;
    cl_nxt.mag  = f.mag;
    cl_nxt.sep  = sep;
    cl_nxt.pen  = err[32] ? PenMax : err[31:0];
    cl_nxt.idx_a = f.idx_a;
    cl_nxt.idx_b = f.idx_b;
    case (f.kind)
      KIND_CABLE: begin
        emit_nxt    = (sep >= lim);
        cl_nxt.flip = 1'b0;
        cl_nxt.rest = f.bounce;
      end
      KIND_ROD: begin
        emit_nxt    = (sep != lim);
        cl_nxt.flip = (sep < lim);
        cl_nxt.rest = '0;
      end
      default: begin
        emit_nxt    = 1'b0;
        cl_nxt.flip = 1'b0;
        cl_nxt.rest = '0;
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r  <= 1'b0;
      p1_vld_r  <= 1'b0;
      sr_vld_r  <= '0;
      cl_vld_r  <= 1'b0;
      cl_emit_r <= 1'b0;
    end else if (adv) begin
      p0_vld_r  <= in_push;
      p1_vld_r  <= p0_vld_r;
      sr_vld_r  <= {sr_vld_r[SqrtSteps-1:0], p1_vld_r};
      cl_vld_r  <= sr_vld_r[SqrtSteps];
      cl_emit_r <= emit_nxt;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      p0_r     <= p0_nxt;
      p1_r     <= p0_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 64'(p0_r.mag[i]) * 64'(p0_r.mag[i]);
      end
      sr_r[0]  <= sr_init;
      for (int k = 0; k < SqrtSteps; k++) begin
        sr_r[k+1] <= root_step(sr_r[k]);
      end
      cl_r     <= cl_nxt;
    end
  end

endmodule

FILE: rtl/core/dcc_back.sv
// ----------------------------------------------------------------------------
// dcc_back
// three-lane pipelined divide forming the unit normal of each contact
// ----------------------------------------------------------------------------
module dcc_back
  import dcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_empty,
  input  mid_t    q_data,
  output logic    q_pop,
  output logic    r_push,
  output result_t r_data,
  input  logic    r_full
);

  logic              adv;
  div_t              dv_init;
  div_t              dv_r [DivSteps+1];
  logic [DivSteps:0] dv_vld_r;
  div_t              dv_nxt [DivSteps];

  assign adv    = ~(dv_vld_r[DivSteps] & r_full);
  assign q_pop  = adv & ~q_empty;
  assign r_push = dv_vld_r[DivSteps] & ~r_full;

  // seed lanes: remainder starts at the magnitude, ratio of one saturates
  always_comb begin
    dv_init   = '0;
    dv_init.m = q_data;
    for (int i = 0; i < 3; i++) begin
      dv_init.rem[i] = {1'b0, q_data.mag[i]};
      dv_init.sat[i] = ({1'b0, q_data.mag[i]} >= q_data.sep);
    end
  end

  // one quotient bit per lane per stage
  always_comb begin
    lane_t ln;
    for (int k = 0; k < DivSteps; k++) begin
      dv_nxt[k] = dv_r[k];
      for (int i = 0; i < 3; i++) begin
        ln.rem = dv_r[k].rem[i];
        ln.quo = dv_r[k].quo[i];
        ln     = div_step(ln, dv_r[k].m.sep);
        dv_nxt[k].rem[i] = ln.rem;
        dv_nxt[k].quo[i] = ln.quo;
      end
    end
  end

  // sign, saturation and zero distance
  always_comb begin
    div_t        d;
    logic [15:0] c;
    d            = dv_r[DivSteps];
    r_data       = '0;
    r_data.pen   = d.m.pen;
    r_data.rest  = d.m.rest;
    r_data.idx_a = d.m.idx_a;
    r_data.idx_b = d.m.idx_b;
    for (int i = 0; i < 3; i++) begin
      if (d.m.sep == '0) begin
        c = '0;
      end else if (d.sat[i]) begin
        c = NormMax;
      end else begin
        c = {1'b0, d.quo[i]};
      end
      r_data.normal[i] = (d.m.neg[i] ^ d.m.flip) ? 16'(-c) : c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r <= '0;
    end else if (adv) begin
      dv_vld_r <= {dv_vld_r[DivSteps-1:0], q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0] <= dv_init;
      for (int k = 0; k < DivSteps; k++) begin
        dv_r[k+1] <= dv_nxt[k];
      end
    end
  end

endmodule

FILE: test/tb_distance_constraint_contact.sv
// ----------------------------------------------------------------------------
// tb_distance_constraint_contact
// stream test of the cable and rod contact generator
// ----------------------------------------------------------------------------
// Constraints are queued by an initial block and pushed in random bursts; each
// transfer is run through a local fixed-point predictor, and contacts popped
// from the block are compared field by field against the oldest predicted one.
module tb_distance_constraint_contact;
  import dcc_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] ax, ay, az, bx, by, bz;
    logic [31:0] limit;
    logic [15:0] bounce, idx_a, idx_b;
  } cons_t;

  typedef struct packed {
    logic [15:0] nx, ny, nz;
    logic [31:0] pen;
    logic [15:0] rest, ca, cb;
  } contact_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic out_pop = 1'b0;
  logic in_full, out_empty;
  cons_t cur = '0;
  logic signed [15:0] o_nx, o_ny, o_nz;
  logic [31:0] o_pen;
  logic [15:0] o_rest, o_ca, o_cb;

  cons_t    pending_cons[$];
  contact_t due_contacts[$];
  int       errors = 0;
  bit       stim_done = 1'b0;
  bit       hold_pop = 1'b0;
  bit       drain_pause = 1'b0;
  bit       in_xfer = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       sent = 0;

  distance_constraint_contact uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_kind(cur.kind),
    .in_first_x(cur.ax), .in_first_y(cur.ay), .in_first_z(cur.az),
    .in_second_x(cur.bx), .in_second_y(cur.by), .in_second_z(cur.bz),
    .in_limit_length(cur.limit), .in_bounce_factor(cur.bounce),
    .in_first_index(cur.idx_a), .in_second_index(cur.idx_b),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_normal_x(o_nx), .out_normal_y(o_ny), .out_normal_z(o_nz),
    .out_penetration(o_pen), .out_contact_restitution(o_rest),
    .out_contact_first(o_ca), .out_contact_second(o_cb)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor square root of the squared distance
  function automatic logic [35:0] floor_root(logic [69:0] s);
    logic [35:0] r;
    logic [35:0] c;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (36'd1 << b);
      if (72'(c) * 72'(c) <= 72'(s)) r = c;
    end
    return r;
  endfunction

  // one normal component in Q1.15
  function automatic logic [15:0] unit_comp(logic signed [33:0] d, logic [35:0] sep,
                                            bit flip);
    logic [33:0] m;
    logic [63:0] q;
    if (sep == 0) return 16'd0;
    m = d[33] ? 34'(-d) : 34'(d);
    q = (64'(m) << 15) / 64'(sep);
    if (q > 64'd32767) q = 64'd32767;
    if ((d < 0) != flip) q = -q;
    return q[15:0];
  endfunction

  // contact prediction; returns 0 when the constraint makes no contact
  function automatic bit predict_contact(cons_t c, output contact_t r);
    logic signed [33:0] dx, dy, dz;
    logic [69:0] sq;
    logic [35:0] sep, pen;
    bit flip;
    dx = 34'(signed'(c.bx)) - 34'(signed'(c.ax));
    dy = 34'(signed'(c.by)) - 34'(signed'(c.ay));
    dz = 34'(signed'(c.bz)) - 34'(signed'(c.az));
    sq = 70'(dx) * 70'(dx) + 70'(dy) * 70'(dy) + 70'(dz) * 70'(dz);
    sep = floor_root(sq);
    flip = 1'b0;
    r = '0;
    if (c.kind == KIND_CABLE) begin
      if (sep < 36'(c.limit)) return 1'b0;
      pen = sep - 36'(c.limit);
    end else begin
      if (sep == 36'(c.limit)) return 1'b0;
      if (sep > 36'(c.limit)) pen = sep - 36'(c.limit);
      else begin
        pen = 36'(c.limit) - sep;
        flip = 1'b1;
      end
    end
    r.nx = unit_comp(dx, sep, flip);
    r.ny = unit_comp(dy, sep, flip);
    r.nz = unit_comp(dz, sep, flip);
    r.pen = (pen > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : pen[31:0];
    r.rest = (c.kind == KIND_CABLE) ? c.bounce : 16'd0;
    r.ca = c.idx_a & IndexMask;
    r.cb = c.idx_b & IndexMask;
    return 1'b1;
  endfunction

  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  // random constraint: modest positions and limit, or arbitrary words when wild
  function automatic cons_t build_cons(bit wild);
    cons_t c;
    int sp;
    c.kind = kind_t'($urandom_range(0, 1));
    sp = $urandom_range(0, 3) == 0 ? 24 : 20;
    if (wild) begin
      c.ax = any_word(); c.ay = any_word(); c.az = any_word();
      c.bx = any_word(); c.by = any_word(); c.bz = any_word();
      c.limit = $urandom;
    end else begin
      c.ax = $signed($urandom) >>> (32 - sp); c.ay = $signed($urandom) >>> (32 - sp);
      c.az = $signed($urandom) >>> (32 - sp); c.bx = $signed($urandom) >>> (32 - sp);
      c.by = $signed($urandom) >>> (32 - sp); c.bz = $signed($urandom) >>> (32 - sp);
      c.limit = $urandom >> (32 - sp);
    end
    c.bounce = $urandom;
    c.idx_a = $urandom;
    c.idx_b = $urandom;
    return c;
  endfunction

  function automatic cons_t pin(kind_t k, logic [31:0] ax, logic [31:0] bx,
                                logic [31:0] by, logic [31:0] lim);
    cons_t c;
    c = '0;
    c.kind = k; c.ax = ax; c.bx = bx; c.by = by; c.limit = lim;
    c.bounce = 16'hFFFF; c.idx_a = 16'hFFFF; c.idx_b = 16'h0001;
    return c;
  endfunction

  // stimulus: directed cases then random mix
  initial begin
    pending_cons.push_back(pin(KIND_CABLE, 0, 0, 0, 0));          // zero distance cable
    pending_cons.push_back(pin(KIND_ROD, 0, 0, 0, 32'h0001_0000)); // zero distance rod
    pending_cons.push_back(pin(KIND_ROD, 0, 0, 0, 0));             // rod at rest
    pending_cons.push_back(pin(KIND_CABLE, 0, 32'h0001_0000, 0, 32'h0001_0000));
    pending_cons.push_back(pin(KIND_CABLE, 0, 32'h0001_0000, 0, 32'h0002_0000));
    pending_cons.push_back(pin(KIND_ROD, 0, 32'hFFFF_0000, 0, 32'h0003_0000));
    pending_cons.push_back(pin(KIND_ROD, 0, 0, 32'h0002_0000, 32'h0001_0000));
    pending_cons.push_back(pin(KIND_ROD, 0, 32'h0001_0000, 0, 32'h0001_0000));
    pending_cons.push_back(pin(KIND_CABLE, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 0));             // penetration saturates
    pending_cons.push_back(pin(KIND_ROD, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF));
    pending_cons.push_back(pin(KIND_ROD, 0, 0, 0, 32'hFFFF_FFFF));
    pending_cons.push_back(pin(KIND_CABLE, 0, 32'h0000_0001, 0, 0));
    for (int i = 0; i < 8; i++) pending_cons.push_back(build_cons(1'b1));
    for (int i = 0; i < 540; i++) pending_cons.push_back(build_cons($urandom_range(0, 4) == 0));
  end

  // input transfer seen at the rising edge, used by the driver
  always @(posedge clk) begin
    in_xfer <= rst_n && in_push && !in_full;
  end

  // driver: bursts with gaps, one drained pause midway
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_xfer) begin
        sent <= sent + 1;
        if (sent + 1 == 300) drain_pause <= 1'b1;
      end
      if (drain_pause && due_contacts.size() == 0 && !in_push) drain_pause <= 1'b0;
      if (in_push && !in_xfer) begin
        // keep offering the same item
      end else if (drain_pause && !(in_xfer && sent + 1 != 300)) begin
        in_push <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_push <= 1'b0;
      end else if (pending_cons.size() == 0 || (in_xfer && sent + 1 == 300)) begin
        in_push <= 1'b0;
        if (pending_cons.size() == 0) stim_done <= 1'b1;
      end else begin
        cur <= pending_cons.pop_front();
        in_push <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        end else burst_left <= burst_left - 1;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (!rst_n || hold_pop) out_pop <= 1'b0;
    else if (sent > 450) out_pop <= 1'b1;
    else out_pop <= ($urandom_range(0, 3) != 0);
  end

  // long receiver hold-off while the sender keeps pushing
  initial begin
    wait (sent >= 80);
    @(negedge clk);
    hold_pop = 1'b1;
    for (int n = 0; n < 200; n++) @(posedge clk);
    @(negedge clk);
    hold_pop = 1'b0;
  end

  // monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin
    contact_t p, exp_c;
    if (rst_n) begin
      if (in_push && !in_full && predict_contact(cur, p)) due_contacts.push_back(p);
      if (out_pop && !out_empty) begin
        if (due_contacts.size() == 0) begin
          $error("unexpected contact");
          errors++;
        end else begin
          exp_c = due_contacts.pop_front();
          if (o_nx !== exp_c.nx) begin
            $error("normal_x exp %h got %h", exp_c.nx, o_nx); errors++;
          end
          if (o_ny !== exp_c.ny) begin
            $error("normal_y exp %h got %h", exp_c.ny, o_ny); errors++;
          end
          if (o_nz !== exp_c.nz) begin
            $error("normal_z exp %h got %h", exp_c.nz, o_nz); errors++;
          end
          if (o_pen !== exp_c.pen) begin
            $error("penetration exp %h got %h", exp_c.pen, o_pen); errors++;
          end
          if (o_rest !== exp_c.rest) begin
            $error("contact_restitution exp %h got %h", exp_c.rest, o_rest); errors++;
          end
          if (o_ca !== exp_c.ca) begin
            $error("contact_first exp %h got %h", exp_c.ca, o_ca); errors++;
          end
          if (o_cb !== exp_c.cb) begin
            $error("contact_second exp %h got %h", exp_c.cb, o_cb); errors++;
          end
        end
      end
    end
  end

  // reset, then wait for the stream to drain
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (stim_done && due_contacts.size() == 0);
    repeat (150) @(posedge clk);
    if (errors == 0 && due_contacts.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
